[rtl/jacobi_symbol_macros.svh]
// ----------------------------------------------------------------------------
// Jacobi symbol assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef JACOBI_SYMBOL_MACROS_SVH
`define JACOBI_SYMBOL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jacobi_symbol: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jacobi_symbol: next-cycle check failed");

`endif

[rtl/jacs_pkg.sv]
// ----------------------------------------------------------------------------
// Jacobi symbol package
// Operand width, step record and symbol codes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jacs_pkg;

  // Working width of the operands; input fields are truncated or zero
  // extended to it.
  localparam int WIDTH      = 32;
  localparam int IN_FIELD_W = 32;

  typedef logic [WIDTH-1:0] word_t;

  // Result of one step of the shared unit.
  typedef struct packed {
    word_t a;
    word_t n;
    logic  flip;
  } step_t;

  // Two's complement symbol codes.
  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  // Residues that flip the sign.
  localparam logic [2:0] MOD8_THREE = 3'd3;
  localparam logic [2:0] MOD8_FIVE  = 3'd5;
  localparam logic [1:0] MOD4_THREE = 2'd3;

endpackage

`default_nettype wire

[rtl/jacs_alu.sv]
// ----------------------------------------------------------------------------
// Jacobi symbol step unit
// One binary Jacobi step: halve an even a, or subtract (swapping when a < n).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jacs_alu (
  input  jacs_pkg::word_t a_i,
  input  jacs_pkg::word_t n_i,
  output jacs_pkg::step_t step_o
);
  import jacs_pkg::*;

  logic [WIDTH:0] diff;
  word_t          neg_diff;

  always_comb begin
    diff     = {1'b0, a_i} - {1'b0, n_i};
    neg_diff = ~diff[WIDTH-1:0] + word_t'(1);
    step_o.a    = a_i;
    step_o.n    = n_i;
    step_o.flip = 1'b0;
    priority if (!a_i[0]) begin
      // factor of two: (2/n) = -1 for n = 3 or 5 mod 8
      step_o.a    = a_i >> 1;
      step_o.flip = (n_i[2:0] == MOD8_THREE) || (n_i[2:0] == MOD8_FIVE);
    end else if (diff[WIDTH]) begin
      // a < n: reciprocity swap, then reduce by the new modulus
      step_o.a    = neg_diff;
      step_o.n    = a_i;
      step_o.flip = (a_i[1:0] == MOD4_THREE) && (n_i[1:0] == MOD4_THREE);
    end else begin
      step_o.a = diff[WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/jacobi_symbol.sv]
// ----------------------------------------------------------------------------
// Jacobi symbol unit
// Computes (a/n) for an unsigned a and an odd modulus n, one beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one beat carries top_value (a) and modulus (n).
//   Output channel out_*: one beat per input beat with the symbol
//   (-1, 0 or +1, two's complement) and a bad_modulus flag.
//   An even or zero modulus is flagged; symbol is then 0.
// Latency / throughput:
//   One item at a time. in_tready is high only while the block is idle.
//   A bad modulus gives its result the cycle after acceptance. Otherwise the
//   binary Jacobi loop runs one step per cycle through the shared step unit
//   (one subtractor/compare plus a shift) until a reaches zero; the run length
//   is set by the number of halvings plus subtract steps.
// Reset:
//   Synchronous, active low; returns to idle and drops out_tvalid.
// Stall:
//   The result is held in registers with out_tvalid high until out_tready;
//   no new beat is taken until then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jacobi_symbol (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata: [31:0] top_value, [63:32] modulus
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: [1:0] symbol, [2] bad_modulus, [7:3] zero
  output logic [7:0]       out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);
  import jacs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t state_r;
  word_t  a_r;
  word_t  n_r;
  logic   neg_r;   // accumulated sign, 1 = negative
  logic   [1:0] sym_r;
  logic   bad_r;

  word_t  top_w;
  word_t  mod_w;
  step_t  step;

  // operands masked / extended to the working width
  assign top_w = word_t'(in_tdata[IN_FIELD_W-1:0]);
  assign mod_w = word_t'(in_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);

  jacs_alu u_alu (
    .a_i    (a_r),
    .n_i    (n_r),
    .step_o (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            a_r   <= top_w;
            n_r   <= mod_w;
            neg_r <= 1'b0;
            if (!mod_w[0]) begin
              // even covers zero as well
              sym_r   <= SYM_ZERO;
              bad_r   <= 1'b1;
              state_r <= S_DONE;
            end else begin
              bad_r   <= 1'b0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (a_r == '0) begin
            // n ends at gcd; only gcd of one gives a nonzero symbol
            if (n_r == word_t'(1)) begin
              sym_r <= neg_r ? SYM_NEG : SYM_POS;
            end else begin
              sym_r <= SYM_ZERO;
            end
            state_r <= S_DONE;
          end else begin
            a_r   <= step.a;
            n_r   <= step.n;
            neg_r <= neg_r ^ step.flip;
          end
        end
        S_DONE: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {5'b0, bad_r, sym_r};

endmodule

`default_nettype wire

[rtl/jacobi_symbol_checker.sv]
// ----------------------------------------------------------------------------
// Jacobi symbol port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "jacobi_symbol_macros.svh"

module jacobi_symbol_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  // stalled result stays up
  `JS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // busy right after taking a beat
  `JS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // never takes a beat while a result waits
  `JS_ASSERT_IMP(a_one_in_flight, clk, rst_n, out_tvalid, !in_tready)
  // flagged modulus gives a zero symbol
  `JS_ASSERT_IMP(a_bad_zero, clk, rst_n, out_tvalid && out_tdata[2], out_tdata[1:0] == 2'b00)
  // symbol is one of -1, 0, +1
  `JS_ASSERT_IMP(a_sym_legal, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'b10)

endmodule

bind jacobi_symbol jacobi_symbol_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

[tb/sv/jacobi_symbol_tb.sv]
// ----------------------------------------------------------------------------
// Jacobi symbol testbench
// Drives (a, n) beats into jacobi_symbol and checks every result beat against
// a behavioral Jacobi predictor or a hand-written directed result. A directed
// table covers the edge cases, then a random mix of odd, small, factor-sharing
// and bad moduli follows. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jacobi_symbol_tb;

  import jacs_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  // Worst-case loop length plus margin; used for the final quiet period.
  localparam int DRAIN_CYCLES = 4 * WIDTH + 8;
  // Cycles without any handshake before the run is declared hung. The slowest
  // legal stretch is a long sender gap, a full loop and a long sink stall.
  localparam int HANG_LIMIT   = 5000;
  localparam int RANDOM_BEATS = 630;
  localparam int CHUNK_BEATS  = 45;
  localparam int NUM_DIRECTED = 22;

  // One expected result, with the operands kept for messages.
  typedef struct packed {
    logic [31:0] top;
    logic [31:0] modulus;
    logic [1:0]  symbol;
    logic        bad;
  } jac_expect_t;

  // Directed row: operands, plus a hand-written result when fixed_exp is set.
  typedef struct packed {
    logic [31:0] top;
    logic [31:0] modulus;
    logic        fixed_exp;
    logic [1:0]  symbol;
    logic        bad;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // zero and even moduli are flagged, symbol 0
    '{32'h0000_0000, 32'h0000_0000, 1'b1, SYM_ZERO, 1'b1},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, SYM_ZERO, 1'b1},
    '{32'h0000_0005, 32'h0000_0002, 1'b1, SYM_ZERO, 1'b1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, SYM_ZERO, 1'b1},
    '{32'h0000_0000, 32'h8000_0000, 1'b1, SYM_ZERO, 1'b1},
    // modulus one gives +1 for any numerator
    '{32'h0000_0000, 32'h0000_0001, 1'b1, SYM_POS,  1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, SYM_POS,  1'b0},
    // zero numerator, modulus above one
    '{32'h0000_0000, 32'h0000_0003, 1'b1, SYM_ZERO, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, SYM_ZERO, 1'b0},
    // a == n reduces to zero; (1/n) = +1
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, SYM_ZERO, 1'b0},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, SYM_POS,  1'b0},
    // (2/3) = -1, (3/9) shares a factor
    '{32'h0000_0002, 32'h0000_0003, 1'b1, SYM_NEG,  1'b0},
    '{32'h0000_0003, 32'h0000_0009, 1'b1, SYM_ZERO, 1'b0},
    // the rest go through the predictor
    '{32'h0000_0002, 32'h0000_0007, 1'b0, SYM_ZERO, 1'b0},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, SYM_ZERO, 1'b0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, SYM_ZERO, 1'b0},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFB, 1'b0, SYM_ZERO, 1'b0},
    '{32'h1234_5678, 32'h7FFF_FFFF, 1'b0, SYM_ZERO, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b0, SYM_ZERO, 1'b0},
    '{32'h0000_03E9, 32'h0000_26B3, 1'b0, SYM_ZERO, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, SYM_ZERO, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAB, 1'b0, SYM_ZERO, 1'b0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [63:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  jac_expect_t pending_q[$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int          sink_stall     = 0;
  // Set for whole stretches of beats in which neither side idles.
  bit          steady_run     = 1'b0;

  jacobi_symbol dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Behavioral Jacobi symbol: reduce, strip twos (mod 8 rule), swap with
  // reciprocity (mod 4 rule), repeat until the numerator is zero.
  function automatic jac_expect_t predict_symbol(logic [31:0] top, logic [31:0] modulus);
    jac_expect_t r;
    word_t       x;
    word_t       m;
    word_t       t;
    bit          neg;
    r.top     = top;
    r.modulus = modulus;
    r.symbol  = SYM_ZERO;
    r.bad     = 1'b0;
    x = word_t'(top);
    m = word_t'(modulus);
    if (m == '0 || !m[0]) begin
      r.bad = 1'b1;
      return r;
    end
    neg = 1'b0;
    x = x % m;
    while (x != '0) begin
      while (!x[0]) begin
        x = x >> 1;
        if (m[2:0] == MOD8_THREE || m[2:0] == MOD8_FIVE) neg = ~neg;
      end
      t = x;
      x = m;
      m = t;
      if (x[1:0] == MOD4_THREE && m[1:0] == MOD4_THREE) neg = ~neg;
      x = x % m;
    end
    if (m == word_t'(1)) r.symbol = neg ? SYM_NEG : SYM_POS;
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random operand pair; mostly odd moduli, a few bad ones as noise.
  task automatic pick_operands(output logic [31:0] top, output logic [31:0] modulus);
    int          roll;
    logic [31:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      top     = $urandom;
      modulus = $urandom | 32'h1;
    end else if (roll < 55) begin
      top     = $urandom_range(0, 300);
      modulus = 2 * $urandom_range(0, 150) + 1;
    end else if (roll < 68) begin
      // common odd factor p, expect plenty of zero symbols
      p       = 2 * $urandom_range(1, 127) + 1;
      top     = p * $urandom_range(0, 1 << 20);
      modulus = p * (2 * $urandom_range(0, 1 << 19) + 1);
    end else if (roll < 76) begin
      top     = $urandom;
      modulus = 2 * $urandom_range(0, 8) + 1;
    end else if (roll < 84) begin
      modulus = 32'hFFFF_FFFF - ($urandom_range(0, 63) << 1);
      top     = $urandom_range(0, 1) ? $urandom : modulus - $urandom_range(0, 7);
    end else if (roll < 92) begin
      // long runs of trailing zeros exercise the halving path
      top     = $urandom << $urandom_range(0, 31);
      modulus = $urandom | 32'h1;
    end else begin
      top     = $urandom;
      modulus = ($urandom_range(0, 7) == 0) ? 32'h0 : ($urandom & 32'hFFFF_FFFE);
    end
  endtask

  // Present one beat and wait for the handshake. Called and returns at a
  // falling edge; in_tvalid is written at most once per edge.
  task automatic send_beat(logic [31:0] top, logic [31:0] modulus, bit fixed_exp,
                           logic [1:0] symbol, logic bad);
    int          gap;
    jac_expect_t e;
    e = predict_symbol(top, modulus);
    if (fixed_exp) begin
      e.symbol = symbol;
      e.bad    = bad;
    end
    gap = steady_run ? 0 : idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {modulus, top};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_q.insert(pending_q.size(), e);
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain_pending();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_q.size() != 0);
  endtask

  // Sink: ready changes on the falling edge, random stalls unless steady.
  initial begin
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        out_tready <= 1'b0;
        sink_stall--;
      end else begin
        out_tready <= 1'b1;
        if (!steady_run) sink_stall = idle_gap();
      end
    end
  end

  // Result checker: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    jac_expect_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result beat: expected none, got tdata %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        e = pending_q.pop_front();
        if (out_tdata[1:0] !== e.symbol) begin
          $display("%0t: symbol for a=%h n=%h: expected %b, got %b",
                   $time, e.top, e.modulus, e.symbol, out_tdata[1:0]);
          mismatch_count++;
        end
        if (out_tdata[2] !== e.bad) begin
          $display("%0t: bad_modulus for a=%h n=%h: expected %b, got %b",
                   $time, e.top, e.modulus, e.bad, out_tdata[2]);
          mismatch_count++;
        end
        if (out_tdata[7:3] !== 5'b0) begin
          $display("%0t: pad bits for a=%h n=%h: expected 00000, got %b",
                   $time, e.top, e.modulus, out_tdata[7:3]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
      $display("jacobi_symbol_tb failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] top;
    logic [31:0] modulus;
    int          sent;
    int          chunk_len;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, hand-written results where they are obvious.
    foreach (DIRECTED[i]) begin
      send_beat(DIRECTED[i].top, DIRECTED[i].modulus, DIRECTED[i].fixed_exp,
                DIRECTED[i].symbol, DIRECTED[i].bad);
    end
    drain_pending();

    // Random part in chunks; some chunks run with no idling at all, and the
    // sender sometimes waits for the pipe to empty between chunks.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      steady_run = ($urandom_range(0, 3) == 0);
      chunk_len  = $urandom_range(CHUNK_BEATS / 2, CHUNK_BEATS);
      for (int i = 0; i < chunk_len && sent < RANDOM_BEATS; i++) begin
        pick_operands(top, modulus);
        send_beat(top, modulus, 1'b0, SYM_ZERO, 1'b0);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) drain_pending();
    end
    steady_run = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    // Quiet period to catch any stray extra beat.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("jacobi_symbol_tb passed");
    end else begin
      $display("jacobi_symbol_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/jacs_pkg.sv
rtl/jacs_alu.sv
rtl/jacobi_symbol.sv
rtl/jacobi_symbol_checker.sv
tb/sv/jacobi_symbol_tb.sv
